@@ design/triangle_classify_area_similarity_assert.svh @@
// Assertion macros shared by the checker of the triangle classifier.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef TRIANGLE_CLASSIFY_AREA_SIMILARITY_ASSERT_SVH
`define TRIANGLE_CLASSIFY_AREA_SIMILARITY_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define TCAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define TCAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ design/tcas_pkg.sv @@
// Package of the triangle classifier: payload structs, widths, latencies.
// Depends on nothing; used by every module of the block.
package tcas_pkg;

  localparam int SIDE_BITS         = 16;
  localparam int COS_FRAC_BITS_DEF = 30;
  localparam int TOL_W             = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd1074;

  localparam int PERIM_W = SIDE_BITS + 2;
  localparam int AREA_W  = 35;

  // Cosine magnitude saturates at 2^62, so it needs 63 bits plus a sign.
  localparam int COS_MAG_W     = 63;
  localparam int COS_W         = COS_MAG_W + 1;
  localparam int COS_LIMIT_BIT = 62;

  // Area lane widths.
  localparam int AR_DIF_W  = SIDE_BITS + 1;
  localparam int AR_P1_W   = PERIM_W + AR_DIF_W;
  localparam int AR_P2_W   = 2 * AR_DIF_W;
  localparam int AR_SPLIT  = AR_P2_W / 2;
  localparam int AR_PROD_W = AR_P1_W + AR_P2_W;
  localparam int AR_RAD_W  = AR_PROD_W + 4;
  localparam int AR_RAD_E  = AR_RAD_W + (AR_RAD_W % 2);
  localparam int AR_ROOT_W = AR_RAD_E / 2;
  localparam int AREA_LAT  = 4 + AR_ROOT_W;

  typedef enum logic [1:0] {
    SHAPE_NONE,
    SHAPE_EQUILATERAL,
    SHAPE_ISOSCELES,
    SHAPE_SCALENE
  } shape_t;

  typedef struct packed {
    logic [SIDE_BITS-1:0] first_side_a;
    logic [SIDE_BITS-1:0] first_side_b;
    logic [SIDE_BITS-1:0] first_side_c;
    logic [SIDE_BITS-1:0] second_side_a;
    logic [SIDE_BITS-1:0] second_side_b;
    logic [SIDE_BITS-1:0] second_side_c;
  } tri_item_t;

  typedef struct packed {
    shape_t             shape_class;
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0]  area_sixteenths;
    logic               similar_flag;
  } tri_result_t;

  // Cosine lane: two product/difference stages, one stage per quotient bit,
  // one saturation stage.
  function automatic int cos_latency(input int frac_bits);
    return (2 * SIDE_BITS + 1) + frac_bits + 3;
  endfunction

endpackage

@@ design/triangle_classify_area_similarity.sv @@
// Top level of the triangle classifier with Heron area and similarity flag.
// Depends on tcas_pkg, tcas_area, tcas_cos and tcas_merge.
//
// Input channel item_valid/item_stall/item_data carries the sides of two
// triangles; a transaction happens when item_valid is high and item_stall low.
// Output channel result_valid/result_stall/result_data carries one result per
// input transaction, in order. cfg_valid/cfg_ready/cfg_data writes the
// similarity tolerance; cfg_ready is always high. Write it only while idle.
//
// The pipeline depth is set by the cosine lanes: one stage per quotient bit
// of the 2*16+1+COS_FRAC_BITS bit divider. The area lane is shorter and is
// padded to match. Throughput is one transaction per cycle while item_stall is low.
//
// The pipeline moves as a whole. It holds only when the output register is
// full, stalled, and the last stage carries a result; item_stall is then high.
// Empty stages drain into the output even while it is stalled.
// Synchronous reset empties the pipeline and loads the tolerance with 1074.
module triangle_classify_area_similarity #(
  parameter int COS_FRAC_BITS = tcas_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  tcas_pkg::tri_item_t        item_data,
  output logic                       result_valid,
  input  logic                       result_stall,
  output tcas_pkg::tri_result_t      result_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcas_pkg::TOL_W-1:0] cfg_data
);

  localparam int COS_LAT = tcas_pkg::cos_latency(COS_FRAC_BITS);
  localparam int LAT     = COS_LAT + 2;
  localparam int PAD     = LAT - tcas_pkg::AREA_LAT;
  localparam int PW      = tcas_pkg::PERIM_W;
  localparam int AW      = tcas_pkg::AREA_W;
  localparam int CW      = tcas_pkg::COS_W;

  logic [tcas_pkg::TOL_W-1:0] tolerance;
  logic [LAT-1:0]             vld;
  logic                       adv;

  tcas_pkg::shape_t a_shape, f_shape;
  logic [PW-1:0]    a_per, f_per;
  logic [AW-1:0]    a_area, f_area;

  logic signed [CW-1:0] cos_a1, cos_b1, cos_a2, cos_b2;
  logic [3:0]           lane_ok;
  logic                 similar;

  assign cfg_ready  = 1'b1;
  assign adv        = !(result_valid && result_stall && vld[LAT-1]);
  assign item_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= tcas_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  tcas_area u_area (
    .clk       (clk),
    .en        (adv),
    .side_a    (item_data.first_side_a),
    .side_b    (item_data.first_side_b),
    .side_c    (item_data.first_side_c),
    .shape     (a_shape),
    .perimeter (a_per),
    .area      (a_area)
  );

  tcas_cos #(.FRAC_BITS(COS_FRAC_BITS)) u_cos_a1 (
    .clk (clk), .en (adv),
    .opp (item_data.first_side_a), .adj1 (item_data.first_side_b),
    .adj2 (item_data.first_side_c),
    .cos_val (cos_a1), .cos_ok (lane_ok[0])
  );

  tcas_cos #(.FRAC_BITS(COS_FRAC_BITS)) u_cos_b1 (
    .clk (clk), .en (adv),
    .opp (item_data.first_side_b), .adj1 (item_data.first_side_a),
    .adj2 (item_data.first_side_c),
    .cos_val (cos_b1), .cos_ok (lane_ok[1])
  );

  tcas_cos #(.FRAC_BITS(COS_FRAC_BITS)) u_cos_a2 (
    .clk (clk), .en (adv),
    .opp (item_data.second_side_a), .adj1 (item_data.second_side_b),
    .adj2 (item_data.second_side_c),
    .cos_val (cos_a2), .cos_ok (lane_ok[2])
  );

  tcas_cos #(.FRAC_BITS(COS_FRAC_BITS)) u_cos_b2 (
    .clk (clk), .en (adv),
    .opp (item_data.second_side_b), .adj1 (item_data.second_side_a),
    .adj2 (item_data.second_side_c),
    .cos_val (cos_b2), .cos_ok (lane_ok[3])
  );

  tcas_merge u_merge (
    .clk     (clk),
    .en      (adv),
    .tol     (tolerance),
    .cos_a1  (cos_a1),
    .cos_b1  (cos_b1),
    .cos_a2  (cos_a2),
    .cos_b2  (cos_b2),
    .lane_ok (lane_ok),
    .similar (similar)
  );

  // Delay the area results so they line up with the similarity flag.
  if (PAD > 0) begin : g_pad
    tcas_pkg::shape_t pd_shape [PAD];
    logic [PW-1:0]    pd_per   [PAD];
    logic [AW-1:0]    pd_area  [PAD];

    always_ff @(posedge clk) begin
      if (adv) begin
        pd_shape[0] <= a_shape;
        pd_per[0]   <= a_per;
        pd_area[0]  <= a_area;
        for (int i = 1; i < PAD; i++) begin
          pd_shape[i] <= pd_shape[i-1];
          pd_per[i]   <= pd_per[i-1];
          pd_area[i]  <= pd_area[i-1];
        end
      end
    end

    assign f_shape = pd_shape[PAD-1];
    assign f_per   = pd_per[PAD-1];
    assign f_area  = pd_area[PAD-1];
  end else begin : g_nopad
    assign f_shape = a_shape;
    assign f_per   = a_per;
    assign f_area  = a_area;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (vld[LAT-1] && adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[LAT-1] && adv) begin
      result_data.shape_class     <= f_shape;
      result_data.perimeter       <= f_per;
      result_data.area_sixteenths <= f_area;
      result_data.similar_flag    <= similar;
    end
  end

endmodule

@@ design/tcas_area.sv @@
// Area lane: triangle test, class, perimeter and Heron area in sixteenths.
// Depends on tcas_pkg; pipelined integer square root, one root bit a stage.
module tcas_area (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tcas_pkg::SIDE_BITS-1:0] side_a,
  input  logic [tcas_pkg::SIDE_BITS-1:0] side_b,
  input  logic [tcas_pkg::SIDE_BITS-1:0] side_c,
  output tcas_pkg::shape_t               shape,
  output logic [tcas_pkg::PERIM_W-1:0]   perimeter,
  output logic [tcas_pkg::AREA_W-1:0]    area
);

  localparam int DW    = tcas_pkg::AR_DIF_W;
  localparam int PW    = tcas_pkg::PERIM_W;
  localparam int P1_W  = tcas_pkg::AR_P1_W;
  localparam int P2_W  = tcas_pkg::AR_P2_W;
  localparam int L     = tcas_pkg::AR_SPLIT;
  localparam int H1_W  = P1_W - L;
  localparam int H2_W  = P2_W - L;
  localparam int PR_W  = tcas_pkg::AR_PROD_W;
  localparam int RE_W  = tcas_pkg::AR_RAD_E;
  localparam int RT_W  = tcas_pkg::AR_ROOT_W;
  localparam int REM_W = RT_W + 2;

  logic [DW-1:0] sum_ab, sum_ac, sum_bc;
  logic          tri_ok;

  logic [DW-1:0]    s0_x, s0_y, s0_z;
  logic [PW-1:0]    s0_per;
  tcas_pkg::shape_t s0_shape;
  logic             s0_tri;

  logic [P1_W-1:0]  s1_p1;
  logic [P2_W-1:0]  s1_p2;
  logic [PW-1:0]    s1_per;
  tcas_pkg::shape_t s1_shape;
  logic             s1_tri;

  logic [H1_W+H2_W-1:0] s2_hh;
  logic [2*L-1:0]       s2_ll;
  logic [H1_W+L-1:0]    s2_m1;
  logic [L+H2_W-1:0]    s2_m2;
  logic [PW-1:0]        s2_per;
  tcas_pkg::shape_t     s2_shape;
  logic                 s2_tri;

  logic [PR_W-1:0]  prod;
  logic [RE_W-1:0]  s3_rad;
  logic [PW-1:0]    s3_per;
  tcas_pkg::shape_t s3_shape;

  logic [REM_W-1:0] sq_rem   [RT_W];
  logic [RT_W-1:0]  sq_root  [RT_W];
  logic [RE_W-1:0]  sq_rad   [RT_W];
  logic [PW-1:0]    sq_per   [RT_W];
  tcas_pkg::shape_t sq_shape [RT_W];

  assign sum_ab = DW'(side_a) + DW'(side_b);
  assign sum_ac = DW'(side_a) + DW'(side_c);
  assign sum_bc = DW'(side_b) + DW'(side_c);
  assign tri_ok = (sum_ab > DW'(side_c)) && (sum_ac > DW'(side_b)) &&
                  (sum_bc > DW'(side_a));

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x   <= sum_bc - DW'(side_a);
      s0_y   <= sum_ac - DW'(side_b);
      s0_z   <= sum_ab - DW'(side_c);
      s0_per <= PW'(side_a) + PW'(side_b) + PW'(side_c);
      s0_tri <= tri_ok;
      if (!tri_ok) begin
        s0_shape <= tcas_pkg::SHAPE_NONE;
      end else if (side_a == side_b && side_b == side_c) begin
        s0_shape <= tcas_pkg::SHAPE_EQUILATERAL;
      end else if (side_a != side_b && side_a != side_c && side_b != side_c) begin
        s0_shape <= tcas_pkg::SHAPE_SCALENE;
      end else begin
        s0_shape <= tcas_pkg::SHAPE_ISOSCELES;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p1    <= s0_per * s0_x;
      s1_p2    <= s0_y * s0_z;
      s1_per   <= s0_per;
      s1_shape <= s0_shape;
      s1_tri   <= s0_tri;
    end
  end

  // The wide product is built from four narrow partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_hh    <= s1_p1[P1_W-1:L] * s1_p2[P2_W-1:L];
      s2_ll    <= s1_p1[L-1:0] * s1_p2[L-1:0];
      s2_m1    <= s1_p1[P1_W-1:L] * s1_p2[L-1:0];
      s2_m2    <= s1_p1[L-1:0] * s1_p2[P2_W-1:L];
      s2_per   <= s1_per;
      s2_shape <= s1_shape;
      s2_tri   <= s1_tri;
    end
  end

  assign prod = {s2_hh, s2_ll} + ((PR_W'(s2_m1) + PR_W'(s2_m2)) << L);

  // Scaling by 16 under the root gives the area in sixteenths.
  always_ff @(posedge clk) begin
    if (en) begin
      s3_rad   <= s2_tri ? RE_W'({prod, 4'b0000}) : '0;
      s3_per   <= s2_per;
      s3_shape <= s2_shape;
    end
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_in;
    logic [RT_W-1:0]  root_in;
    logic [RE_W-1:0]  rad_in;
    logic [PW-1:0]    per_in;
    tcas_pkg::shape_t shape_in;
    logic [REM_W-1:0] trial_rem;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in   = '0;
      assign root_in  = '0;
      assign rad_in   = s3_rad;
      assign per_in   = s3_per;
      assign shape_in = s3_shape;
    end else begin : g_next
      assign rem_in   = sq_rem[k-1];
      assign root_in  = sq_root[k-1];
      assign rad_in   = sq_rad[k-1];
      assign per_in   = sq_per[k-1];
      assign shape_in = sq_shape[k-1];
    end

    assign trial_rem = {rem_in[REM_W-3:0], rad_in[RE_W-1:RE_W-2]};
    assign trial     = {root_in, 2'b01};
    assign ge        = trial_rem >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k]   <= ge ? trial_rem - trial : trial_rem;
        sq_root[k]  <= {root_in[RT_W-2:0], ge};
        sq_rad[k]   <= rad_in << 2;
        sq_per[k]   <= per_in;
        sq_shape[k] <= shape_in;
      end
    end
  end

  assign shape     = sq_shape[RT_W-1];
  assign perimeter = sq_per[RT_W-1];
  assign area      = sq_root[RT_W-1][tcas_pkg::AREA_W-1:0];

endmodule

@@ design/tcas_cos.sv @@
// Cosine lane: cos = (s1^2 + s2^2 - opp^2) / (2*s1*s2) in signed fixed point.
// Depends on tcas_pkg; pipelined restoring divider, one quotient bit a stage.
module tcas_cos #(
  parameter int FRAC_BITS = tcas_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [tcas_pkg::SIDE_BITS-1:0]   opp,
  input  logic [tcas_pkg::SIDE_BITS-1:0]   adj1,
  input  logic [tcas_pkg::SIDE_BITS-1:0]   adj2,
  output logic signed [tcas_pkg::COS_W-1:0] cos_val,
  output logic                             cos_ok
);

  localparam int SB        = tcas_pkg::SIDE_BITS;
  localparam int MAG_W     = 2 * SB + 1;
  localparam int DEN_W     = 2 * SB + 1;
  localparam int NW        = MAG_W + FRAC_BITS;
  localparam int SAT_SHIFT = tcas_pkg::COS_MAG_W - FRAC_BITS;
  localparam int QX_W      = (NW > tcas_pkg::COS_MAG_W) ? NW : tcas_pkg::COS_MAG_W;
  localparam int MW        = tcas_pkg::COS_MAG_W;

  logic [2*SB-1:0] c0_sq1, c0_sq2, c0_sqo, c0_p12;
  logic            c0_ok;

  logic [MAG_W-1:0] pos, negv, d_pn, d_np;
  logic             is_neg;
  logic [MAG_W-1:0] mag;

  logic [MAG_W-1:0] c1_mag;
  logic [DEN_W-1:0] c1_den;
  logic             c1_neg, c1_sat, c1_ok;

  logic [DEN_W-1:0] dv_rem [NW];
  logic [NW-1:0]    dv_quo [NW];
  logic [NW-1:0]    dv_num [NW];
  logic [DEN_W-1:0] dv_den [NW];
  logic             dv_neg [NW];
  logic             dv_sat [NW];
  logic             dv_ok  [NW];

  logic [QX_W-1:0] qx, lim, qs;
  logic [MW-1:0]   qmag;

  always_ff @(posedge clk) begin
    if (en) begin
      c0_sq1 <= adj1 * adj1;
      c0_sq2 <= adj2 * adj2;
      c0_sqo <= opp * opp;
      c0_p12 <= adj1 * adj2;
      c0_ok  <= (adj1 != '0) && (adj2 != '0);
    end
  end

  assign pos    = MAG_W'(c0_sq1) + MAG_W'(c0_sq2);
  assign negv   = MAG_W'(c0_sqo);
  assign is_neg = pos < negv;
  assign d_pn   = pos - negv;
  assign d_np   = negv - pos;
  assign mag    = is_neg ? d_np : d_pn;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_mag <= mag;
      c1_den <= {c0_p12, 1'b0};
      c1_neg <= is_neg;
      c1_sat <= (mag >> SAT_SHIFT) != '0;
      c1_ok  <= c0_ok;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DEN_W-1:0] rem_in;
    logic [NW-1:0]    quo_in;
    logic [NW-1:0]    num_in;
    logic [DEN_W-1:0] den_in;
    logic             neg_in, sat_in, ok_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = {c1_mag, {FRAC_BITS{1'b0}}};
      assign den_in = c1_den;
      assign neg_in = c1_neg;
      assign sat_in = c1_sat;
      assign ok_in  = c1_ok;
    end else begin : g_next
      assign rem_in = dv_rem[k-1];
      assign quo_in = dv_quo[k-1];
      assign num_in = dv_num[k-1];
      assign den_in = dv_den[k-1];
      assign neg_in = dv_neg[k-1];
      assign sat_in = dv_sat[k-1];
      assign ok_in  = dv_ok[k-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dv_quo[k] <= {quo_in[NW-2:0], ge};
        dv_num[k] <= num_in << 1;
        dv_den[k] <= den_in;
        dv_neg[k] <= neg_in;
        dv_sat[k] <= sat_in;
        dv_ok[k]  <= ok_in;
      end
    end
  end

  assign qx   = QX_W'(dv_quo[NW-1]);
  assign lim  = QX_W'(1) << tcas_pkg::COS_LIMIT_BIT;
  assign qs   = (dv_sat[NW-1] || qx > lim) ? lim : qx;
  assign qmag = qs[MW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= dv_neg[NW-1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      cos_ok  <= dv_ok[NW-1];
    end
  end

endmodule

@@ design/tcas_merge.sv @@
// Merge stage: compares the cosines of both triangles against the tolerance.
// Depends on tcas_pkg; two register stages.
module tcas_merge (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tcas_pkg::TOL_W-1:0]        tol,
  input  logic signed [tcas_pkg::COS_W-1:0] cos_a1,
  input  logic signed [tcas_pkg::COS_W-1:0] cos_b1,
  input  logic signed [tcas_pkg::COS_W-1:0] cos_a2,
  input  logic signed [tcas_pkg::COS_W-1:0] cos_b2,
  input  logic [3:0]                        lane_ok,
  output logic                              similar
);

  localparam int DF_W = tcas_pkg::COS_W + 1;

  logic signed [DF_W-1:0] d_a, d_b;
  logic                   m_ok;
  logic signed [DF_W-1:0] tol_pos, tol_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      d_a  <= DF_W'(cos_a1) - DF_W'(cos_a2);
      d_b  <= DF_W'(cos_b1) - DF_W'(cos_b2);
      m_ok <= &lane_ok;
    end
  end

  // |d| < tol is checked as -tol < d < tol, both compares in parallel.
  assign tol_pos = $signed({{(DF_W - tcas_pkg::TOL_W){1'b0}}, tol});
  assign tol_neg = -tol_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      similar <= m_ok && (d_a < tol_pos) && (d_a > tol_neg) &&
                 (d_b < tol_pos) && (d_b > tol_neg);
    end
  end

endmodule

@@ design/tcas_checker.sv @@
// Port-level checker of the triangle classifier and its bind statement.
// Depends on tcas_pkg and triangle_classify_area_similarity_assert.svh.
`include "triangle_classify_area_similarity_assert.svh"

module tcas_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input tcas_pkg::tri_result_t result_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  // A stalled result must stay put until the transaction completes.
  `TCAS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_data), "stalled result changed")
  // The input is held back only by a full, stalled output register.
  `TCAS_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall, "input stalled without output backpressure")
  // A first triangle that fails the inequality has no area.
  `TCAS_ASSERT_NOW(a_none_area, result_valid && result_data.shape_class == tcas_pkg::SHAPE_NONE, result_data.area_sixteenths == '0, "area reported for a non-triangle")
  // The tolerance register never refuses a write.
  `TCAS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind triangle_classify_area_similarity tcas_checker u_tcas_checker (.*);
